// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is low
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also runs during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/cso_pkg.sv =====
// ----------------------------------------------------------------------------
// cso_pkg
// shared constants and types of the circle / square overlap test
// ----------------------------------------------------------------------------
package cso_pkg;

    // default coordinate width (signed, fixed point)
    localparam int CSO_COORD_BITS = 24;

    // tolerance register
    localparam int          TOL_W     = 8;
    localparam logic [7:0]  TOL_RESET = 8'd1;

    // result stream width
    localparam int OUT_TDATA_W = 8;

    // kind of question carried down the pipe
    typedef enum logic [2:0] {
        MODE_PT_CIRC,
        MODE_PT_SQ,
        MODE_CC,
        MODE_SS,
        MODE_SC
    } cso_mode_t;

endpackage

// ===== rtl/core/circle_square_overlap_test.sv =====
// ----------------------------------------------------------------------------
// circle_square_overlap_test
// point-in-shape and shape-overlap test for circles and axis-aligned squares
// ----------------------------------------------------------------------------
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser: req_type, a_kind, b_kind
//                                                 tdata: a_x, a_y, a_size, b_x, b_y, b_size
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: hit
//  cfg       in   cfg_we                          cfg_wdata: tolerance
//
//  one item per cycle while m_axis takes results, through the stage 1 to 4 and output registers
//  the depth is set by the squaring multipliers and the wide distance compare
//  rst_n clears all valid bits and sets tolerance to one
//  when the output register holds an untaken result the whole pipe freezes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_square_overlap_test
    import cso_pkg::*;
#(
    parameter int COORD_BITS = CSO_COORD_BITS,
    localparam int TDW = ((6 * COORD_BITS - 2 + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config
    input  logic                   cfg_we,
    input  logic [TOL_W-1:0]       cfg_wdata,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDW-1:0]         s_axis_tdata,   // a_x, a_y, a_size, b_x, b_y, b_size
    input  logic [2:0]             s_axis_tuser,   // req_type, a_kind, b_kind
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hit
);

    localparam int CB = COORD_BITS;
    localparam int SW = CB - 1;
    localparam int DW = CB + 3;
    localparam int LW = ((CB > 9) ? CB : 9) + 1;
    localparam int UW = 2 * DW - 2;
    localparam int QW = 2 * DW - 1;

    localparam int O_AX = 0;
    localparam int O_AY = O_AX + CB;
    localparam int O_AS = O_AY + CB;
    localparam int O_BX = O_AS + SW;
    localparam int O_BY = O_BX + CB;
    localparam int O_BS = O_BY + CB;

    function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
        mag_f = v[DW-1] ? -v : v;
    endfunction

    // tolerance register
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    // pipe advance
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic [4:0] pipe_v;

    assign adv           = !out_v_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign pipe_v        = {v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= s_axis_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            out_v_reg <= v4_reg;
        end
    end

    // stage 1: input capture
    logic                 req1_reg, asq1_reg, bsq1_reg;
    logic signed [CB-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic [SW-1:0]        as1_reg, bs1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req1_reg <= s_axis_tuser[0];
            asq1_reg <= s_axis_tuser[1];
            bsq1_reg <= s_axis_tuser[2];
            ax1_reg  <= s_axis_tdata[O_AX +: CB];
            ay1_reg  <= s_axis_tdata[O_AY +: CB];
            as1_reg  <= s_axis_tdata[O_AS +: SW];
            bx1_reg  <= s_axis_tdata[O_BX +: CB];
            by1_reg  <= s_axis_tdata[O_BY +: CB];
            bs1_reg  <= s_axis_tdata[O_BS +: SW];
        end
    end

    // stage 2: center differences in half-lsb units, limits, mode
    logic signed [DW-1:0] dx2_next, dy2_next;
    logic [LW-1:0]        la2_next, lb2_next, rop2_next;
    cso_mode_t            mode2_next;

    always_comb
    begin
        dx2_next = DW'($signed({bx1_reg, 1'b0})) - DW'($signed({ax1_reg, 1'b0}));
        dy2_next = DW'($signed({by1_reg, 1'b0})) - DW'($signed({ay1_reg, 1'b0}));
        la2_next = LW'(as1_reg) + LW'({tol_reg, 1'b0});
        lb2_next = LW'(bs1_reg) + LW'({tol_reg, 1'b0});
        if (!req1_reg)
        begin
            mode2_next = asq1_reg ? MODE_PT_SQ : MODE_PT_CIRC;
            rop2_next  = la2_next;
        end
        else if (!asq1_reg && !bsq1_reg)
        begin
            mode2_next = MODE_CC;
            rop2_next  = LW'(as1_reg) + LW'(bs1_reg);
        end
        else if (asq1_reg && bsq1_reg)
        begin
            mode2_next = MODE_SS;
            rop2_next  = la2_next;
        end
        else
        begin
            mode2_next = MODE_SC;
            rop2_next  = asq1_reg ? lb2_next : la2_next;
        end
    end

    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic [LW-1:0]        la2_reg, lb2_reg, rop2_reg;
    cso_mode_t            mode2_reg;
    logic                 asq2_reg;
    logic [SW-1:0]        as2_reg, bs2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx2_reg   <= dx2_next;
            dy2_reg   <= dy2_next;
            la2_reg   <= la2_next;
            lb2_reg   <= lb2_next;
            rop2_reg  <= rop2_next;
            mode2_reg <= mode2_next;
            asq2_reg  <= asq1_reg;
            as2_reg   <= as1_reg;
            bs2_reg   <= bs1_reg;
        end
    end

    // stage 3: corner offsets
    logic signed [DW-1:0] ex3, ey3, ssz3, asz3, bsz3;

    assign ex3  = asq2_reg ? -dx2_reg : dx2_reg;
    assign ey3  = asq2_reg ? -dy2_reg : dy2_reg;
    assign asz3 = DW'(as2_reg);
    assign bsz3 = DW'(bs2_reg);
    assign ssz3 = asq2_reg ? asz3 : bsz3;

    logic signed [DW-1:0] uxm3_reg, uxp3_reg, vym3_reg, vyp3_reg;
    logic signed [DW-1:0] dxma3_reg, dxpa3_reg, dyma3_reg, dypa3_reg;
    logic signed [DW-1:0] dxmb3_reg, dxpb3_reg, dymb3_reg, dypb3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic [LW-1:0]        la3_reg, lb3_reg, ls3_reg, rop3_reg;
    logic [SW-1:0]        csz3_reg;
    cso_mode_t            mode3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uxm3_reg  <= ex3 - ssz3;
            uxp3_reg  <= ex3 + ssz3;
            vym3_reg  <= ey3 - ssz3;
            vyp3_reg  <= ey3 + ssz3;
            dxma3_reg <= dx2_reg - asz3;
            dxpa3_reg <= dx2_reg + asz3;
            dyma3_reg <= dy2_reg - asz3;
            dypa3_reg <= dy2_reg + asz3;
            dxmb3_reg <= dx2_reg - bsz3;
            dxpb3_reg <= dx2_reg + bsz3;
            dymb3_reg <= dy2_reg - bsz3;
            dypb3_reg <= dy2_reg + bsz3;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            la3_reg   <= la2_reg;
            lb3_reg   <= lb2_reg;
            ls3_reg   <= asq2_reg ? la2_reg : lb2_reg;
            rop3_reg  <= rop2_reg;
            csz3_reg  <= asq2_reg ? bs2_reg : as2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    // stage 4: squares and linear compares
    logic signed [2*DW-1:0] pdx4, pdy4, puxm4, puxp4, pvym4, pvyp4;
    logic [2*LW-1:0]        pr4;
    logic [DW-1:0]          mdx4, mdy4, la4, lb4, ls4, csz4;
    logic                   ptsq4, scin4, ss4;
    logic                   nuxm4, nuxp4, nvym4, nvyp4, btx4, bty4;

    always_comb
    begin
        pdx4  = dx3_reg * dx3_reg;
        pdy4  = dy3_reg * dy3_reg;
        puxm4 = uxm3_reg * uxm3_reg;
        puxp4 = uxp3_reg * uxp3_reg;
        pvym4 = vym3_reg * vym3_reg;
        pvyp4 = vyp3_reg * vyp3_reg;
        pr4   = rop3_reg * rop3_reg;
        mdx4  = mag_f(dx3_reg);
        mdy4  = mag_f(dy3_reg);
        la4   = DW'(la3_reg);
        lb4   = DW'(lb3_reg);
        ls4   = DW'(ls3_reg);
        csz4  = DW'(csz3_reg);
        ptsq4 = (mdx4 <= la4) && (mdy4 <= la4);
        scin4 = (mdx4 <= ls4) && (mdy4 <= ls4);
        // a corner of either square inside the other
        ss4   = (((mag_f(dxma3_reg) <= lb4) || (mag_f(dxpa3_reg) <= lb4)) &&
                 ((mag_f(dyma3_reg) <= lb4) || (mag_f(dypa3_reg) <= lb4))) ||
                (((mag_f(dxmb3_reg) <= la4) || (mag_f(dxpb3_reg) <= la4)) &&
                 ((mag_f(dymb3_reg) <= la4) || (mag_f(dypb3_reg) <= la4)));
        // side line closer than the circle diameter
        nuxm4 = mag_f(uxm3_reg) < csz4;
        nuxp4 = mag_f(uxp3_reg) < csz4;
        nvym4 = mag_f(vym3_reg) < csz4;
        nvyp4 = mag_f(vyp3_reg) < csz4;
        // center projection strictly between the side ends
        btx4  = (uxm3_reg[DW-1] && !uxp3_reg[DW-1] && (uxp3_reg != '0)) ||
                (uxp3_reg[DW-1] && !uxm3_reg[DW-1] && (uxm3_reg != '0));
        bty4  = (vym3_reg[DW-1] && !vyp3_reg[DW-1] && (vyp3_reg != '0)) ||
                (vyp3_reg[DW-1] && !vym3_reg[DW-1] && (vym3_reg != '0));
    end

    logic [UW-1:0]     sdx4_reg, sdy4_reg, suxm4_reg, suxp4_reg, svym4_reg, svyp4_reg;
    logic [2*LW-1:0]   sr4_reg;
    logic              ptsq4_reg, scin4_reg, ss4_reg;
    logic              nuxm4_reg, nuxp4_reg, nvym4_reg, nvyp4_reg, btx4_reg, bty4_reg;
    cso_mode_t         mode4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sdx4_reg  <= pdx4[UW-1:0];
            sdy4_reg  <= pdy4[UW-1:0];
            suxm4_reg <= puxm4[UW-1:0];
            suxp4_reg <= puxp4[UW-1:0];
            svym4_reg <= pvym4[UW-1:0];
            svyp4_reg <= pvyp4[UW-1:0];
            sr4_reg   <= pr4;
            ptsq4_reg <= ptsq4;
            scin4_reg <= scin4;
            ss4_reg   <= ss4;
            nuxm4_reg <= nuxm4;
            nuxp4_reg <= nuxp4;
            nvym4_reg <= nvym4;
            nvyp4_reg <= nvyp4;
            btx4_reg  <= btx4;
            bty4_reg  <= bty4;
            mode4_reg <= mode3_reg;
        end
    end

    // stage 5: distance sums against the squared limit, final select
    logic [QW-1:0] dist5, cmm5, cpm5, cmp5, cpp5, r5;
    logic          imm5, ipm5, imp5, ipp5, sides5, hit_next;

    always_comb
    begin
        dist5  = QW'(sdx4_reg) + QW'(sdy4_reg);
        cmm5   = QW'(suxm4_reg) + QW'(svym4_reg);
        cpm5   = QW'(suxp4_reg) + QW'(svym4_reg);
        cmp5   = QW'(suxm4_reg) + QW'(svyp4_reg);
        cpp5   = QW'(suxp4_reg) + QW'(svyp4_reg);
        r5     = QW'(sr4_reg);
        imm5   = cmm5 <= r5;
        ipm5   = cpm5 <= r5;
        imp5   = cmp5 <= r5;
        ipp5   = cpp5 <= r5;
        sides5 = (nvyp4_reg && (imp5 || ipp5 || btx4_reg)) ||
                 (nvym4_reg && (imm5 || ipm5 || btx4_reg)) ||
                 (nuxm4_reg && (imm5 || imp5 || bty4_reg)) ||
                 (nuxp4_reg && (ipm5 || ipp5 || bty4_reg));
        case (mode4_reg) inside
            MODE_PT_CIRC, MODE_CC: hit_next = dist5 <= r5;
            MODE_PT_SQ:            hit_next = ptsq4_reg;
            MODE_SS:               hit_next = ss4_reg;
            MODE_SC:               hit_next = scin4_reg || sides5;
            default:               hit_next = 1'b0;
        endcase
    end

    // output register
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(hit_reg);

    // checks
    `ASSERT_CLK(a_stall_freeze, clk, rst_n, !s_axis_tready |=> $stable(pipe_v), "pipe moved during stall")
    `ASSERT_CLK(a_accept_s1, clk, rst_n, s_axis_tvalid && s_axis_tready |=> v1_reg, "transfer lost at stage 1")
    `ASSERT_CLK(a_out_source, clk, rst_n, $rose(m_axis_tvalid) |-> $past(v4_reg), "result without item")

endmodule
